### hw/rtl/cbmt_pkg.sv
`default_nettype none

package cbmt_pkg;

    localparam int NUM_COUNTERS_DEF = 16;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int CMD_W     = 3;
    localparam int INDEX_W   = 4;
    localparam int SLOT_W    = 4;
    localparam int OUT_CNT_W = 16;
    localparam int NUM_W     = 5;

    localparam logic [NUM_W-1:0] LIST_MAX = 5'd16;
    localparam logic [NUM_W-1:0] NUM_SAT  = 5'd31;

    localparam logic [CMD_W-1:0] CMD_INC  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST = 3'd4;

    typedef struct packed {
        logic load;
        logic update;
        logic find_max;
        logic find_eq;
        logic count;
        logic emit_one;
        logic scan;
    } t_ctrl;

    typedef struct packed {
        logic is_list;
        logic scan_last;
    } t_stat;

endpackage

`default_nettype wire

### hw/rtl/counter_bank_with_max_tracking.sv
// A single-result word goes through the update, maximum, match, count and emit steps; busy stays
// high until its result is registered, so a new word is taken only once the sequencer is idle.
// A list word instead scans the counters in index order after the count step, up to the last
// holder of the maximum, and gives one result per holder; busy holds until that holder is reached.
// Results are strobed for one cycle and cannot be held off by the receiver.
// Synchronous active-low reset clears every counter to zero and returns the sequencer to idle.
`default_nettype none

module counter_bank_with_max_tracking #(
    parameter int NUM_COUNTERS = cbmt_pkg::NUM_COUNTERS_DEF,
    parameter int COUNT_BITS   = cbmt_pkg::COUNT_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire  [cbmt_pkg::CMD_W-1:0]            i_cmd,
    input  wire  [cbmt_pkg::INDEX_W-1:0]          i_index,
    output logic                                  o_valid,
    output logic [cbmt_pkg::SLOT_W-1:0]           o_slot,
    output logic signed [cbmt_pkg::OUT_CNT_W-1:0] o_slot_count,
    output logic signed [cbmt_pkg::OUT_CNT_W-1:0] o_max_count,
    output logic [cbmt_pkg::NUM_W-1:0]            o_num_at_max,
    output logic                                  o_last
);

    cbmt_pkg::t_ctrl ctrl;
    cbmt_pkg::t_stat stat;

    cbmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .busy    (busy)
    );

    cbmt_datapath #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_index      (i_index),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_slot       (o_slot),
        .o_slot_count (o_slot_count),
        .o_max_count  (o_max_count),
        .o_num_at_max (o_num_at_max),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

### hw/rtl/cbmt_datapath.sv
`default_nettype none

module cbmt_datapath #(
    parameter int NUM_COUNTERS = cbmt_pkg::NUM_COUNTERS_DEF,
    parameter int COUNT_BITS   = cbmt_pkg::COUNT_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  [cbmt_pkg::CMD_W-1:0]           i_cmd,
    input  wire  [cbmt_pkg::INDEX_W-1:0]         i_index,
    input  wire  cbmt_pkg::t_ctrl                i_ctrl,
    output cbmt_pkg::t_stat                      o_stat,
    output logic                                 o_valid,
    output logic [cbmt_pkg::SLOT_W-1:0]          o_slot,
    output logic signed [cbmt_pkg::OUT_CNT_W-1:0] o_slot_count,
    output logic signed [cbmt_pkg::OUT_CNT_W-1:0] o_max_count,
    output logic [cbmt_pkg::NUM_W-1:0]           o_num_at_max,
    output logic                                 o_last
);

    localparam int IW    = $clog2(NUM_COUNTERS);
    localparam int XW    = IW + cbmt_pkg::INDEX_W;
    localparam int LV    = $clog2(NUM_COUNTERS);
    localparam int TW    = 2 ** LV;
    localparam int POP_W = $clog2(NUM_COUNTERS + 1);

    localparam logic signed [COUNT_BITS-1:0] CNT_TOP = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] CNT_BOT = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic signed [COUNT_BITS-1:0] r_counts [NUM_COUNTERS];
    logic [cbmt_pkg::CMD_W-1:0]   r_cmd;
    logic [cbmt_pkg::INDEX_W-1:0] r_index;
    logic signed [COUNT_BITS-1:0] r_max;
    logic [NUM_COUNTERS-1:0]      r_eq;
    logic [cbmt_pkg::NUM_W-1:0]   r_num;
    logic [cbmt_pkg::NUM_W-1:0]   r_total;
    logic [IW-1:0]                r_ptr;
    logic [cbmt_pkg::NUM_W-1:0]   r_sent;

    logic                                 r_valid;
    logic [cbmt_pkg::SLOT_W-1:0]          r_slot;
    logic signed [cbmt_pkg::OUT_CNT_W-1:0] r_slot_count;
    logic signed [cbmt_pkg::OUT_CNT_W-1:0] r_max_out;
    logic [cbmt_pkg::NUM_W-1:0]           r_num_out;
    logic                                 r_last;

    logic [XW-1:0]                idx_ext;
    logic [IW-1:0]                idx_w;
    logic                         in_range;
    logic                         is_list;
    logic signed [COUNT_BITS-1:0] cur;
    logic signed [COUNT_BITS-1:0] n_cur;
    logic signed [COUNT_BITS-1:0] tree [LV+1][TW];
    logic [POP_W-1:0]             pop_sum;
    logic [7:0]                   pop_ext;
    logic [cbmt_pkg::NUM_W-1:0]   n_num;
    logic [cbmt_pkg::NUM_W-1:0]   n_total;
    logic                         hit;
    logic                         hit_last;
    logic signed [31:0]           cur_wide;
    logic signed [31:0]           max_wide;

    assign idx_ext  = XW'(r_index);
    assign idx_w    = idx_ext[IW-1:0];
    assign in_range = idx_ext < XW'(NUM_COUNTERS);
    assign is_list  = r_cmd == cbmt_pkg::CMD_LIST;
    assign cur      = in_range ? r_counts[idx_w] : '0;
    assign cur_wide = 32'(cur);
    assign max_wide = 32'(r_max);
    assign hit      = r_eq[r_ptr];
    assign hit_last = hit && ((r_sent + 5'd1) == r_total);

    assign o_stat = '{is_list: is_list, scan_last: hit_last};

    always_comb begin
        n_cur = cur;
        case (r_cmd)
            cbmt_pkg::CMD_INC: begin
                if (cur != CNT_TOP) begin
                    n_cur = cur + 1'b1;
                end
            end
            cbmt_pkg::CMD_DEC: begin
                if (cur != CNT_BOT) begin
                    n_cur = cur - 1'b1;
                end
            end
            cbmt_pkg::CMD_CLR: n_cur = '0;
            default:           n_cur = cur;
        endcase
    end

    always_comb begin
        for (int l = 0; l <= LV; l++) begin
            for (int j = 0; j < TW; j++) begin
                tree[l][j] = CNT_BOT;
            end
        end
        for (int j = 0; j < NUM_COUNTERS; j++) begin
            tree[0][j] = r_counts[j];
        end
        for (int l = 0; l < LV; l++) begin
            for (int j = 0; j < TW; j++) begin
                if (j < (TW >> (l + 1))) begin
                    tree[l+1][j] = (tree[l][2*j] > tree[l][2*j+1]) ?
                                   tree[l][2*j] : tree[l][2*j+1];
                end
            end
        end
    end

    always_comb begin
        pop_sum = '0;
        for (int k = 0; k < NUM_COUNTERS; k++) begin
            pop_sum = pop_sum + POP_W'(r_eq[k]);
        end
        pop_ext = 8'(pop_sum);
        n_num   = (pop_ext > 8'(cbmt_pkg::NUM_SAT)) ? cbmt_pkg::NUM_SAT : pop_ext[4:0];
        n_total = (pop_ext > 8'(cbmt_pkg::LIST_MAX)) ? cbmt_pkg::LIST_MAX : pop_ext[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                r_counts[k] <= '0;
            end
        end else if (i_ctrl.update && in_range && !is_list) begin
            r_counts[idx_w] <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd   <= i_cmd;
            r_index <= i_index;
        end
        if (i_ctrl.find_max) begin
            r_max <= tree[LV][0];
        end
        if (i_ctrl.find_eq) begin
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                r_eq[k] <= r_counts[k] == r_max;
            end
        end
        if (i_ctrl.count) begin
            r_num   <= n_num;
            r_total <= n_total;
            r_ptr   <= '0;
            r_sent  <= '0;
        end else if (i_ctrl.scan) begin
            r_ptr <= r_ptr + 1'b1;
            if (hit) begin
                r_sent <= r_sent + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.emit_one || (i_ctrl.scan && hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit_one) begin
            r_slot       <= r_index;
            r_slot_count <= cur_wide[cbmt_pkg::OUT_CNT_W-1:0];
            r_max_out    <= max_wide[cbmt_pkg::OUT_CNT_W-1:0];
            r_num_out    <= r_num;
            r_last       <= 1'b1;
        end else if (i_ctrl.scan && hit) begin
            r_slot       <= cbmt_pkg::SLOT_W'(r_ptr);
            r_slot_count <= max_wide[cbmt_pkg::OUT_CNT_W-1:0];
            r_max_out    <= max_wide[cbmt_pkg::OUT_CNT_W-1:0];
            r_num_out    <= r_num;
            r_last       <= hit_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_slot       = r_slot;
    assign o_slot_count = r_slot_count;
    assign o_max_count  = r_max_out;
    assign o_num_at_max = r_num_out;
    assign o_last       = r_last;

endmodule

`default_nettype wire

### hw/rtl/cbmt_ctrl.sv
`default_nettype none

module cbmt_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              start,
    input  wire  cbmt_pkg::t_stat i_stat,
    output cbmt_pkg::t_ctrl  o_ctrl,
    output logic             busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_MAX  = 3'd2;
    localparam logic [2:0] S_EQ   = 3'd3;
    localparam logic [2:0] S_POP  = 3'd4;
    localparam logic [2:0] S_ONE  = 3'd5;
    localparam logic [2:0] S_SCAN = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign busy = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_UPD;
                end
            end
            S_UPD: begin
                o_ctrl.update = 1'b1;
                n_state       = S_MAX;
            end
            S_MAX: begin
                o_ctrl.find_max = 1'b1;
                n_state         = S_EQ;
            end
            S_EQ: begin
                o_ctrl.find_eq = 1'b1;
                n_state        = S_POP;
            end
            S_POP: begin
                o_ctrl.count = 1'b1;
                n_state      = i_stat.is_list ? S_SCAN : S_ONE;
            end
            S_ONE: begin
                o_ctrl.emit_one = 1'b1;
                n_state         = S_IDLE;
            end
            S_SCAN: begin
                o_ctrl.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### dv/tb_counter_bank_with_max_tracking.sv
`timescale 1ns / 100ps

typedef struct packed {
    logic [3:0]         slot;
    logic signed [15:0] slot_count;
    logic signed [15:0] max_count;
    logic [4:0]         num_at_max;
    logic               last;
} t_bank_result;

class bank_scoreboard;
    localparam logic signed [15:0] COUNT_TOP    = 16'sh7FFF;
    localparam logic signed [15:0] COUNT_BOTTOM = 16'sh8000;

    logic signed [15:0] tally [16];
    t_bank_result       pending [64];
    logic [5:0]         head;
    logic [5:0]         tail;
    int                 held;
    int                 errors;
    int                 words_seen;
    int                 results_seen;
    int                 longest_list;
    logic signed [15:0] lowest_peak;

    function new();
        foreach (tally[k]) tally[k] = '0;
        head         = '0;
        tail         = '0;
        held         = 0;
        errors       = 0;
        words_seen   = 0;
        results_seen = 0;
        longest_list = 0;
        lowest_peak  = '0;
    endfunction

    function void store(t_bank_result r);
        pending[tail] = r;
        tail++;
        held++;
    endfunction

    function void find_peak(output logic signed [15:0] peak, output logic [4:0] holders);
        peak    = tally[0];
        holders = '0;
        for (int k = 1; k < 16; k++) begin
            if (tally[k] > peak) peak = tally[k];
        end
        for (int k = 0; k < 16; k++) begin
            if (tally[k] == peak) holders++;
        end
        if (peak < lowest_peak) lowest_peak = peak;
    endfunction

    function void note_word(logic [2:0] cmd, logic [3:0] index);
        t_bank_result       r;
        logic signed [15:0] peak;
        logic [4:0]         holders;
        int                 emitted;
        words_seen++;
        if (cmd == cbmt_pkg::CMD_LIST) begin
            find_peak(peak, holders);
            emitted = 0;
            for (int k = 0; k < 16; k++) begin
                if (tally[k] == peak && emitted < int'(holders)) begin
                    r.slot       = 4'(k);
                    r.slot_count = tally[k];
                    r.max_count  = peak;
                    r.num_at_max = holders;
                    r.last       = (emitted == int'(holders) - 1);
                    store(r);
                    emitted++;
                end
            end
            if (emitted > longest_list) longest_list = emitted;
        end else begin
            case (cmd)
                cbmt_pkg::CMD_INC: begin
                    if (tally[index] != COUNT_TOP) tally[index] = tally[index] + 16'sd1;
                end
                cbmt_pkg::CMD_DEC: begin
                    if (tally[index] != COUNT_BOTTOM) tally[index] = tally[index] - 16'sd1;
                end
                cbmt_pkg::CMD_CLR: begin
                    tally[index] = '0;
                end
                default: begin
                end
            endcase
            find_peak(peak, holders);
            r.slot       = index;
            r.slot_count = tally[index];
            r.max_count  = peak;
            r.num_at_max = holders;
            r.last       = 1'b1;
            store(r);
        end
    endfunction

    function void check_result(logic [3:0] slot, logic signed [15:0] slot_count,
                               logic signed [15:0] max_count, logic [4:0] num_at_max,
                               logic last);
        t_bank_result want;
        results_seen++;
        if (held == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("ERROR: unexpected result slot %0d count %0d max %0d num %0d last %0b",
                         slot, slot_count, max_count, num_at_max, last);
            end
            return;
        end
        want = pending[head];
        head++;
        held--;
        if (want.slot !== slot || want.slot_count !== slot_count
                || want.max_count !== max_count || want.num_at_max !== num_at_max
                || want.last !== last) begin
            errors++;
            if (errors <= 10) begin
                $display("ERROR: expected slot %0d count %0d max %0d num %0d last %0b",
                         want.slot, want.slot_count, want.max_count, want.num_at_max,
                         want.last);
                $display("       actual   slot %0d count %0d max %0d num %0d last %0b",
                         slot, slot_count, max_count, num_at_max, last);
            end
        end
    endfunction

    function int left();
        return held;
    endfunction
endclass

module tb_counter_bank_with_max_tracking;

    localparam logic [cbmt_pkg::CMD_W-1:0] CMD_SPARE5 = 3'd5;
    localparam logic [cbmt_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [cbmt_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;
    localparam int RANDOM_WORDS   = 140;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 12;

    logic                                  i_clk   = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  start   = 1'b0;
    logic [cbmt_pkg::CMD_W-1:0]            i_cmd   = '0;
    logic [cbmt_pkg::INDEX_W-1:0]          i_index = '0;
    logic                                  busy;
    logic                                  o_valid;
    logic [cbmt_pkg::SLOT_W-1:0]           o_slot;
    logic signed [cbmt_pkg::OUT_CNT_W-1:0] o_slot_count;
    logic signed [cbmt_pkg::OUT_CNT_W-1:0] o_max_count;
    logic [cbmt_pkg::NUM_W-1:0]            o_num_at_max;
    logic                                  o_last;

    bank_scoreboard sb = new();
    int             stall_cycles = 0;
    int             burst_left   = 0;

    counter_bank_with_max_tracking u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_index      (i_index),
        .o_valid      (o_valid),
        .o_slot       (o_slot),
        .o_slot_count (o_slot_count),
        .o_max_count  (o_max_count),
        .o_num_at_max (o_num_at_max),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_result(o_slot, o_slot_count, o_max_count, o_num_at_max, o_last);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", sb.left());
            $display("tb_counter_bank_with_max_tracking: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // The word is held until the block takes it; bursts end in a random pause.
    task automatic send_word(input logic [cbmt_pkg::CMD_W-1:0] cmd,
                             input logic [cbmt_pkg::INDEX_W-1:0] index);
        int gap;
        i_cmd   <= cmd;
        i_index <= index;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_word(cmd, index);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 7);
        end
    endtask

    initial begin
        int                         pick;
        int                         n;
        int                         random_words;
        logic [cbmt_pkg::CMD_W-1:0] cmd;
        logic [3:0]                 idx;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(cbmt_pkg::CMD_LIST, 4'd0);
        send_word(cbmt_pkg::CMD_READ, 4'd0);
        send_word(cbmt_pkg::CMD_READ, 4'd15);
        send_word(cbmt_pkg::CMD_INC, 4'd15);
        send_word(cbmt_pkg::CMD_INC, 4'd15);
        send_word(cbmt_pkg::CMD_INC, 4'd10);
        send_word(CMD_SPARE5, 4'd5);
        send_word(CMD_SPARE6, 4'd10);
        send_word(CMD_SPARE7, 4'd15);
        send_word(cbmt_pkg::CMD_LIST, 4'd15);
        send_word(cbmt_pkg::CMD_DEC, 4'd15);
        send_word(cbmt_pkg::CMD_LIST, 4'd10);
        send_word(cbmt_pkg::CMD_INC, 4'd10);
        send_word(cbmt_pkg::CMD_CLR, 4'd10);
        send_word(cbmt_pkg::CMD_DEC, 4'd0);
        send_word(cbmt_pkg::CMD_DEC, 4'd5);
        send_word(cbmt_pkg::CMD_CLR, 4'd15);
        send_word(cbmt_pkg::CMD_LIST, 4'd5);
        send_word(cbmt_pkg::CMD_CLR, 4'd0);
        send_word(cbmt_pkg::CMD_CLR, 4'd5);
        send_word(cbmt_pkg::CMD_READ, 4'd3);

        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                idx = 4'($urandom_range(0, 15));
                n   = $urandom_range(1, 6);
                cmd = $urandom_range(0, 1) ? cbmt_pkg::CMD_INC : cbmt_pkg::CMD_DEC;
                repeat (n) send_word(cmd, idx);
                send_word(cbmt_pkg::CMD_LIST, 4'($urandom_range(0, 15)));
                random_words += n + 1;
            end else if (pick < 6) begin
                cmd = (pick == 4) ? cbmt_pkg::CMD_DEC : cbmt_pkg::CMD_CLR;
                for (int k = 0; k < 16; k++) send_word(cmd, 4'(k));
                send_word(cbmt_pkg::CMD_LIST, 4'($urandom_range(0, 15)));
                random_words += 17;
            end else begin
                send_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
                random_words += 1;
            end
        end
        start <= 1'b0;

        while (sb.left() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d words and %0d results over every command code,",
                 sb.words_seen, sb.results_seen);
        $display("lists of up to %0d holders and a maximum as low as %0d.",
                 sb.longest_list, sb.lowest_peak);
        if (sb.errors == 0 && sb.left() == 0) begin
            $display("tb_counter_bank_with_max_tracking: PASS");
        end else begin
            $display("%0d mismatches, %0d results never seen.", sb.errors, sb.left());
            $display("tb_counter_bank_with_max_tracking: FAIL");
        end
        $finish;
    end
endmodule
